// ===== sv/tolerant_double_compare_top_macros.svh =====
// Assertion macros for the tolerant double compare block.
// Used by the top level; no other dependencies.
`ifndef TOLERANT_DOUBLE_COMPARE_TOP_MACROS_SVH
`define TOLERANT_DOUBLE_COMPARE_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define TDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define TDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/tdc_pkg.sv =====
// Package for the tolerant double compare block: result codes, epsilon
// constants and the mantissa bit-length helper. No dependencies.
package tdc_pkg;

  typedef enum logic [1:0] {
    ORDER_LESS    = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_GREATER = 2'd2
  } order_e;

  localparam int unsigned MantW = 52;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned SigW  = MantW + 1;
  // Signed width for exponent arithmetic.
  localparam int unsigned EW    = 14;

  localparam logic signed [EW-1:0] EpsLog2Single = -14'sd23;
  localparam logic signed [EW-1:0] EpsLog2Double = -14'sd52;
  localparam logic signed [EW-1:0] MinSubLog2    = -14'sd1074;

  // Position of the leading one plus one; zero for an all-zero word.
  function automatic logic [5:0] bit_length(input logic [MantW-1:0] m);
    logic [5:0] len;
    len = '0;
    for (int i = 0; i < MantW; i++) begin
      if (m[i]) begin
        len = 6'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

// ===== sv/tdc_core.sv =====
// Combinational tolerant compare of two double bit patterns.
// Depends on tdc_pkg.
module tdc_core import tdc_pkg::*; (
  input  logic [63:0] first_value_i,
  input  logic [63:0] second_value_i,
  input  logic        precision_single_i,
  output order_e      order_o
);

  logic             s1, s2, nan1, nan2, inf1, inf2, first_big, far;
  logic [ExpW-1:0]  ex1, ex2, e1f, e2f, exbig, exsmall, exb_raw, diffe;
  logic [MantW-1:0] mb;
  logic [SigW-1:0]  sig1, sig2;
  logic [SigW:0]    a1, a2;
  logic [SigW+1:0]  dd;
  logic [SigW:0]    mag;
  logic signed [EW-1:0] e, k, p;
  logic             dzero, over, big_neg;

  always_comb begin
    s1   = first_value_i[63];
    s2   = second_value_i[63];
    ex1  = first_value_i[62:52];
    ex2  = second_value_i[62:52];
    nan1 = (&ex1) && (first_value_i[51:0] != '0);
    nan2 = (&ex2) && (second_value_i[51:0] != '0);
    inf1 = (&ex1) && (first_value_i[51:0] == '0);
    inf2 = (&ex2) && (second_value_i[51:0] == '0);
    e1f  = (ex1 == '0) ? ExpW'(1) : ex1;
    e2f  = (ex2 == '0) ? ExpW'(1) : ex2;
    sig1 = {ex1 != '0, first_value_i[51:0]};
    sig2 = {ex2 != '0, second_value_i[51:0]};

    // Strict magnitude test; ties pick the second operand.
    first_big = first_value_i[62:0] > second_value_i[62:0];
    exbig     = first_big ? e1f : e2f;
    exsmall   = first_big ? e2f : e1f;
    exb_raw   = first_big ? ex1 : ex2;
    mb        = first_big ? first_value_i[51:0] : second_value_i[51:0];
    big_neg   = first_big ? s1 : ~s2;
    diffe     = exbig - exsmall;
    far       = diffe >= ExpW'(2);

    // Exact magnitude difference on the common grid of the smaller exponent.
    a1  = (e1f > exsmall) ? {sig1, 1'b0} : {1'b0, sig1};
    a2  = (e2f > exsmall) ? {sig2, 1'b0} : {1'b0, sig2};
    dd  = {1'b0, a1} - {1'b0, a2};
    mag = dd[SigW+1] ? (SigW+1)'(0) - dd[SigW:0] : dd[SigW:0];

    // frexp exponent of the larger operand and log2 of delta.
    if (exb_raw != '0) begin
      e = EW'({3'b000, exb_raw}) - EW'(1022);
    end else if (mb == '0) begin
      e = '0;
    end else begin
      e = EW'({8'b0, bit_length(mb)}) + MinSubLog2;
    end
    k     = e + (precision_single_i ? EpsLog2Single : EpsLog2Double);
    dzero = k < MinSubLog2;
    // Delta's position in units of the difference's lsb.
    p     = k + EW'(1075) - EW'({3'b000, exsmall});

    if (dzero || p < 0) begin
      over = mag != '0;
    end else if (p >= EW'(SigW + 1)) begin
      over = 1'b0;
    end else begin
      over = mag > ((SigW+1)'(1) << p[5:0]);
    end

    if (nan1 || nan2) begin
      order_o = ORDER_EQUAL;
    end else if (inf1 && inf2) begin
      order_o = (s1 == s2) ? ORDER_EQUAL : (s1 ? ORDER_LESS : ORDER_GREATER);
    end else if (inf1) begin
      order_o = s1 ? ORDER_LESS : ORDER_GREATER;
    end else if (inf2) begin
      order_o = s2 ? ORDER_GREATER : ORDER_LESS;
    end else if (far) begin
      order_o = big_neg ? ORDER_LESS : ORDER_GREATER;
    end else if (s1 != s2) begin
      // Opposite signs: the magnitudes add, so only two zeros compare equal.
      if ((first_value_i[62:0] == '0) && (second_value_i[62:0] == '0)) begin
        order_o = ORDER_EQUAL;
      end else begin
        order_o = s1 ? ORDER_LESS : ORDER_GREATER;
      end
    end else if (over) begin
      // Same sign: a negative pair flips the direction of the magnitude gap.
      order_o = (dd[SigW+1] ^ s1) ? ORDER_LESS : ORDER_GREATER;
    end else begin
      order_o = ORDER_EQUAL;
    end
  end

endmodule

// ===== sv/tolerant_double_compare_top.sv =====
// Top level of the tolerant double compare block.
// Depends on tdc_pkg, tdc_core and tolerant_double_compare_top_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one transaction made of
//   two double bit patterns and a precision select. Output channel
//   (out_valid_o / out_ready_i) returns one order code per transaction:
//   less, equal within tolerance, or greater.
//   Stages: an accepted transaction goes to the input register, then its
//   order code to the result register (two register stages). Throughput:
//   one transaction per cycle while out_ready_i is high; the whole compare
//   is one pass of combinational logic between the two stages.
//   Reset: rst_ni clears both stage valid flags; payload registers keep
//   whatever they hold.
//   Stall: when out_ready_i is low the result register holds, the input
//   stage fills, and in_ready_o drops only once both stages are full.
`include "tolerant_double_compare_top_macros.svh"
module tolerant_double_compare_top import tdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] first_value_i,
  input  logic [63:0] second_value_i,
  input  logic        precision_single_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  order_o
);

  // Input stage.
  logic        s1_v_q;
  logic [63:0] a_q, b_q;
  logic        sgl_q;
  // Result stage.
  logic        s2_v_q;
  order_e      order_q, order_d;
  logic        s1_go, in_take;

  // Advance the input stage when the result stage is empty or draining.
  assign s1_go      = !s2_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_take    = in_valid_i && in_ready_o;

  tdc_core u_core (
    .first_value_i     (a_q),
    .second_value_i    (b_q),
    .precision_single_i(sgl_q),
    .order_o           (order_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (s1_go) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_q   <= first_value_i;
      b_q   <= second_value_i;
      sgl_q <= precision_single_i;
    end
    if (s1_go && s1_v_q) begin
      order_q <= order_d;
    end
  end

  assign out_valid_o = s2_v_q;
  assign order_o     = order_q;

  `TDC_ASSERT(a_take_fills, in_take |=> s1_v_q, "accepted transaction lost at input stage")
  `TDC_ASSERT(a_hold_s1, (s1_v_q && !s1_go) |=> (s1_v_q && $stable(a_q) && $stable(b_q)), "stalled input stage changed")
  `TDC_ASSERT(a_move_s2, (s1_v_q && s1_go) |=> out_valid_o, "result not delivered to output stage")
  `TDC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!s1_v_q && !s2_v_q), "stages not empty in reset")

endmodule
